>>> hw/rtl/tsb_pkg.sv
`default_nettype none
package tsb_pkg;

  localparam int CAPACITY  = 48;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int SUM_W     = CNT_W + 2;
  localparam int MID_RESET = CAPACITY / 3;

  localparam int OPCODE_W = 3;
  localparam int SEL_W    = 2;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic [OPCODE_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PEEK  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DROP  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 3'd5;

  localparam logic [SEL_W-1:0] SEL_BOTTOM = 2'd0;
  localparam logic [SEL_W-1:0] SEL_TOP    = 2'd1;
  localparam logic [SEL_W-1:0] SEL_MIDDLE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Control broadcast to every storage cell along the chain.
  typedef struct packed {
    logic                     shift_up;
    logic                     shift_down;
    logic                     wr_en;
    logic [IDX_W-1:0]         slot;
    logic signed [WORD_W-1:0] wr_value;
    logic [CNT_W:0]           mid_lo;
    logic [CNT_W:0]           mid_hi;
  } cell_ctrl_t;

  // Result of an operation, presented in the cycle it commits.
  typedef struct packed {
    logic                fire;
    logic                rd_en;
    logic [STATUS_W-1:0] status;
    logic                empty;
  } apply_t;

endpackage
`default_nettype wire

>>> hw/rtl/tsb_if.sv
`default_nettype none
interface tsb_req_if;
  logic                             valid;
  logic                             ready;
  logic [tsb_pkg::OPCODE_W-1:0]     opcode;
  logic [tsb_pkg::SEL_W-1:0]        stack_select;
  logic signed [tsb_pkg::WORD_W-1:0] push_value;

  modport source (output valid, opcode, stack_select, push_value, input ready);
  modport sink (input valid, opcode, stack_select, push_value, output ready);
endinterface

interface tsb_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [tsb_pkg::WORD_W-1:0] read_value;
  logic [tsb_pkg::STATUS_W-1:0]      status;
  logic                              stack_empty;

  modport source (output valid, read_value, status, stack_empty, input ready);
  modport sink (input valid, read_value, status, stack_empty, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tsb_cell.sv
`default_nettype none
module tsb_cell (
  input  wire logic                              clk_i,
  input  wire logic [tsb_pkg::IDX_W-1:0]         idx_i,
  input  wire tsb_pkg::cell_ctrl_t               ctrl_i,
  input  wire logic signed [tsb_pkg::WORD_W-1:0] left_i,
  input  wire logic signed [tsb_pkg::WORD_W-1:0] right_i,
  output logic signed [tsb_pkg::WORD_W-1:0]      word_o,
  output logic signed [tsb_pkg::WORD_W-1:0]      rd_o
);

  logic signed [tsb_pkg::WORD_W-1:0] word_q, word_d;
  logic [tsb_pkg::CNT_W:0]           idx_ext, idx_nxt;
  logic                              up_hit, down_hit, wr_hit;

  assign idx_ext = (tsb_pkg::CNT_W + 1)'(idx_i);
  assign idx_nxt = idx_ext + 1'b1;

  // Moving up, a cell inside (base, base+count] takes its lower neighbor's word.
  // Moving down, a cell whose upper neighbor is in [base, base+count) takes it.
  assign up_hit   = ctrl_i.shift_up && (idx_ext > ctrl_i.mid_lo) &&
                    (idx_ext <= ctrl_i.mid_hi);
  assign down_hit = ctrl_i.shift_down && (idx_nxt >= ctrl_i.mid_lo) &&
                    (idx_nxt < ctrl_i.mid_hi);
  assign wr_hit   = ctrl_i.wr_en && (idx_i == ctrl_i.slot);

  always_comb begin
    word_d = word_q;
    if (wr_hit) begin
      word_d = ctrl_i.wr_value;
    end else if (up_hit) begin
      word_d = left_i;
    end else if (down_hit) begin
      word_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign rd_o   = (idx_i == ctrl_i.slot) ? word_q : '0;

endmodule
`default_nettype wire

>>> hw/rtl/tsb_ctrl.sv
`default_nettype none
module tsb_ctrl (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              req_valid_i,
  input  wire logic [tsb_pkg::OPCODE_W-1:0]      req_opcode_i,
  input  wire logic [tsb_pkg::SEL_W-1:0]         req_sel_i,
  input  wire logic signed [tsb_pkg::WORD_W-1:0] req_value_i,
  input  wire logic                              out_free_i,
  output logic                                   req_ready_o,
  output tsb_pkg::cell_ctrl_t                    cell_ctrl_o,
  output tsb_pkg::apply_t                        apply_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_APP  = 2'd2;

  localparam int CW = tsb_pkg::CNT_W;
  localparam int SW = tsb_pkg::SUM_W;

  typedef struct packed {
    logic [CW-1:0]                 bc;
    logic [CW-1:0]                 tc;
    logic [CW-1:0]                 mc;
    logic [CW-1:0]                 base;
    logic                          shift_up;
    logic                          shift_down;
    logic                          wr_en;
    logic                          rd_en;
    logic [tsb_pkg::IDX_W-1:0]     slot;
    logic [tsb_pkg::STATUS_W-1:0]  status;
    logic                          empty;
  } plan_t;

  logic [1:0] state_q, state_d;
  logic [tsb_pkg::OPCODE_W-1:0]      opcode_q;
  logic [tsb_pkg::SEL_W-1:0]         sel_q;
  logic signed [tsb_pkg::WORD_W-1:0] value_q;
  logic [CW-1:0] bc_q, tc_q, mc_q, base_q;
  plan_t plan_q, plan_d;

  logic          finish, accept;
  logic [CW:0]   mid_end, top_edge;
  logic [SW-1:0] total;
  logic          full, meet;
  logic [CW-1:0] depth;

  assign finish      = (state_q == S_APP) && out_free_i;
  assign req_ready_o = (state_q == S_IDLE) || finish;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    case (state_q)
      S_IDLE:  state_d = accept ? S_DEC : S_IDLE;
      S_DEC:   state_d = S_APP;
      S_APP:   state_d = finish ? (accept ? S_DEC : S_IDLE) : S_APP;
      default: state_d = S_IDLE;
    endcase
  end

  assign mid_end  = {1'b0, base_q} + {1'b0, mc_q};
  assign top_edge = (CW + 1)'(tsb_pkg::CAPACITY) - {1'b0, tc_q};
  assign total    = SW'(bc_q) + SW'(tc_q) + SW'(mc_q);
  assign full     = total >= SW'(tsb_pkg::CAPACITY);
  // The middle stack touches the top stack and has room to move down.
  assign meet     = (mid_end == top_edge) && (base_q != '0);

  always_comb begin
    case (sel_q)
      tsb_pkg::SEL_BOTTOM: depth = bc_q;
      tsb_pkg::SEL_TOP:    depth = tc_q;
      tsb_pkg::SEL_MIDDLE: depth = mc_q;
      default:             depth = '0;
    endcase
  end

  always_comb begin
    plan_d            = '0;
    plan_d.bc         = bc_q;
    plan_d.tc         = tc_q;
    plan_d.mc         = mc_q;
    plan_d.base       = base_q;
    plan_d.status     = tsb_pkg::ST_OK;
    case (opcode_q)
      tsb_pkg::OP_PUSH: begin
        if (full || (sel_q != tsb_pkg::SEL_BOTTOM && sel_q != tsb_pkg::SEL_TOP &&
                     sel_q != tsb_pkg::SEL_MIDDLE)) begin
          plan_d.status = tsb_pkg::ST_FULL;
        end else begin
          plan_d.wr_en = 1'b1;
          case (sel_q)
            tsb_pkg::SEL_BOTTOM: begin
              plan_d.shift_up = (bc_q == base_q);
              plan_d.base     = base_q + CW'(bc_q == base_q);
              plan_d.slot     = tsb_pkg::IDX_W'(bc_q);
              plan_d.bc       = bc_q + 1'b1;
            end
            tsb_pkg::SEL_TOP: begin
              plan_d.shift_down = meet;
              plan_d.base       = base_q - CW'(meet);
              plan_d.slot       = tsb_pkg::IDX_W'(top_edge - 1'b1);
              plan_d.tc         = tc_q + 1'b1;
            end
            default: begin
              plan_d.shift_down = meet;
              plan_d.base       = base_q - CW'(meet);
              plan_d.slot       = tsb_pkg::IDX_W'(mid_end - (CW + 1)'(meet));
              plan_d.mc         = mc_q + 1'b1;
            end
          endcase
        end
      end
      tsb_pkg::OP_POP, tsb_pkg::OP_PEEK, tsb_pkg::OP_DROP: begin
        if (depth == '0) begin
          plan_d.status = tsb_pkg::ST_EMPTY;
        end else begin
          plan_d.rd_en = (opcode_q != tsb_pkg::OP_DROP);
          case (sel_q)
            tsb_pkg::SEL_BOTTOM: plan_d.slot = tsb_pkg::IDX_W'(bc_q - 1'b1);
            tsb_pkg::SEL_TOP:    plan_d.slot = tsb_pkg::IDX_W'(top_edge);
            default:             plan_d.slot = tsb_pkg::IDX_W'(mid_end - 1'b1);
          endcase
          if (opcode_q != tsb_pkg::OP_PEEK) begin
            case (sel_q)
              tsb_pkg::SEL_BOTTOM: plan_d.bc = bc_q - 1'b1;
              tsb_pkg::SEL_TOP:    plan_d.tc = tc_q - 1'b1;
              default:             plan_d.mc = mc_q - 1'b1;
            endcase
          end
        end
      end
      tsb_pkg::OP_CLEAR: begin
        plan_d.bc   = '0;
        plan_d.tc   = '0;
        plan_d.mc   = '0;
        plan_d.base = CW'(tsb_pkg::MID_RESET);
      end
      default: begin
      end
    endcase
    case (sel_q)
      tsb_pkg::SEL_BOTTOM: plan_d.empty = (plan_d.bc == '0);
      tsb_pkg::SEL_TOP:    plan_d.empty = (plan_d.tc == '0);
      tsb_pkg::SEL_MIDDLE: plan_d.empty = (plan_d.mc == '0);
      default:             plan_d.empty = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bc_q    <= '0;
      tc_q    <= '0;
      mc_q    <= '0;
      base_q  <= CW'(tsb_pkg::MID_RESET);
    end else begin
      state_q <= state_d;
      if (finish) begin
        bc_q   <= plan_q.bc;
        tc_q   <= plan_q.tc;
        mc_q   <= plan_q.mc;
        base_q <= plan_q.base;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      opcode_q <= req_opcode_i;
      sel_q    <= req_sel_i;
      value_q  <= req_value_i;
    end
    if (state_q == S_DEC) begin
      plan_q <= plan_d;
    end
  end

  // The counts still hold their old values while the cells move.
  always_comb begin
    cell_ctrl_o.shift_up   = plan_q.shift_up && finish;
    cell_ctrl_o.shift_down = plan_q.shift_down && finish;
    cell_ctrl_o.wr_en      = plan_q.wr_en && finish;
    cell_ctrl_o.slot       = plan_q.slot;
    cell_ctrl_o.wr_value   = value_q;
    cell_ctrl_o.mid_lo     = {1'b0, base_q};
    cell_ctrl_o.mid_hi     = mid_end;
  end

  always_comb begin
    apply_o.fire   = finish;
    apply_o.rd_en  = plan_q.rd_en;
    apply_o.status = plan_q.status;
    apply_o.empty  = plan_q.empty;
  end

endmodule
`default_nettype wire

>>> hw/rtl/three_stacks_shared_buffer.sv
// Three stacks of signed 32-bit words share a row of 48 storage cells: the bottom stack
// grows up from cell 0, the top stack grows down from the last cell, and the middle stack
// starts a third of the way up and moves one cell at a time, each of its cells taking its
// neighbor's word in the same clock, when an outer stack pushes into it or it pushes into
// the top stack. Each request does one push, pop, peek, drop or empty query on one stack,
// clears all three, or with a spare opcode does nothing, and gives exactly one response.
// A request is captured at the edge that accepts it; it is then decoded against the stack
// counts into the plan register, and in the commit state the cells move and the response
// register loads. A new request is accepted in the commit cycle of the previous one, so
// the block takes a new request while it commits the last one but not while it decodes;
// a stalled response holds the commit cycle until it is taken. No clearing pass follows
// reset: words are never read before a push has written them.
`default_nettype none
module three_stacks_shared_buffer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tsb_req_if.sink    req_i,
  tsb_rsp_if.source  rsp_o
);

  localparam int CAP = tsb_pkg::CAPACITY;

  tsb_pkg::cell_ctrl_t cell_ctrl;
  tsb_pkg::apply_t     apply;

  logic signed [tsb_pkg::WORD_W-1:0] words [CAP];
  logic signed [tsb_pkg::WORD_W-1:0] rd_words [CAP];
  logic signed [tsb_pkg::WORD_W-1:0] rd_word;

  logic                              out_valid_q;
  logic signed [tsb_pkg::WORD_W-1:0] read_value_q;
  logic [tsb_pkg::STATUS_W-1:0]      status_q;
  logic                              empty_q;
  logic                              out_free;

  assign out_free = !out_valid_q || rsp_o.ready;

  tsb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_opcode_i (req_i.opcode),
    .req_sel_i    (req_i.stack_select),
    .req_value_i  (req_i.push_value),
    .out_free_i   (out_free),
    .req_ready_o  (req_i.ready),
    .cell_ctrl_o  (cell_ctrl),
    .apply_o      (apply)
  );

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic signed [tsb_pkg::WORD_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = words[i-1];
    end
    if (i == CAP - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = words[i+1];
    end
    tsb_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (tsb_pkg::IDX_W'(i)),
      .ctrl_i  (cell_ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (words[i]),
      .rd_o    (rd_words[i])
    );
  end

  // Only the addressed cell drives a non-zero read word.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAP; i++) begin
      rd_word = rd_word | rd_words[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (apply.fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply.fire) begin
      read_value_q <= apply.rd_en ? rd_word : '0;
      status_q     <= apply.status;
      empty_q      <= apply.empty;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_value  = read_value_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.stack_empty = empty_q;

endmodule
`default_nettype wire

>>> hw/rtl/tsb_checker.sv
`default_nettype none
module tsb_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              req_valid_i,
  input wire logic                              req_ready_i,
  input wire logic                              rsp_valid_i,
  input wire logic                              rsp_ready_i,
  input wire logic signed [tsb_pkg::WORD_W-1:0] rsp_read_value_i,
  input wire logic [tsb_pkg::STATUS_W-1:0]      rsp_status_i,
  input wire logic                              rsp_stack_empty_i
);

  // A response that is not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response withdrawn before it was taken");

  // Right after a request is taken the block is busy decoding it.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted during decode");

  // A fresh response always belongs to the request taken just before the decode and commit states that led to it.
  a_rsp_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_valid_i && req_ready_i, 3))
    else $error("response without a matching request");

  // An empty-stack refusal returns no data and reports the stack as empty.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == tsb_pkg::ST_EMPTY |->
      rsp_read_value_i == '0 && rsp_stack_empty_i)
    else $error("empty status with data or a non-empty stack");

endmodule

bind three_stacks_shared_buffer tsb_checker u_tsb_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_read_value_i  (rsp_o.read_value),
  .rsp_status_i      (rsp_o.status),
  .rsp_stack_empty_i (rsp_o.stack_empty)
);
`default_nettype wire

>>> bench/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsb_pkg::*;

  // Codes the package leaves unnamed: a stack select that names no stack and the spare opcodes.
  localparam logic [SEL_W-1:0]    SEL_NONE = 2'd3;
  localparam logic [OPCODE_W-1:0] OP_NOP6  = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_NOP7  = 3'd7;

  localparam int CYCLE_LIMIT = 100000;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [STATUS_W-1:0]      status;
    logic                     stack_empty;
  } stack_result_t;

  logic clk_i;
  logic rst_ni;

  tsb_req_if req_bus ();
  tsb_rsp_if rsp_bus ();

  three_stacks_shared_buffer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Shadow copy of the buffer and the three stacks.
  logic signed [WORD_W-1:0] shadow_words [CAPACITY];
  int bottom_depth;
  int top_depth;
  int middle_base;
  int middle_depth;

  stack_result_t pending_results[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_hold = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int depth_of(logic [SEL_W-1:0] sel);
    case (sel)
      SEL_BOTTOM: return bottom_depth;
      SEL_TOP:    return top_depth;
      SEL_MIDDLE: return middle_depth;
      default:    return 0;
    endcase
  endfunction

  function automatic void shift_middle_up();
    for (int i = middle_depth; i >= 1; i--) begin
      if (middle_base + i < CAPACITY)
        shadow_words[middle_base + i] = shadow_words[middle_base + i - 1];
    end
    middle_base++;
  endfunction

  function automatic void shift_middle_down();
    if (middle_base == 0) return;
    for (int i = 0; i < middle_depth; i++) begin
      if (middle_base + i < CAPACITY)
        shadow_words[middle_base + i - 1] = shadow_words[middle_base + i];
    end
    middle_base--;
  endfunction

  function automatic logic [STATUS_W-1:0] push_word(logic [SEL_W-1:0] sel,
                                                    logic signed [WORD_W-1:0] value);
    int slot;
    if (sel == SEL_NONE) return ST_FULL;
    if (bottom_depth + top_depth + middle_depth >= CAPACITY) return ST_FULL;
    case (sel)
      SEL_BOTTOM: begin
        if (bottom_depth == middle_base) shift_middle_up();
        slot = bottom_depth;
        bottom_depth++;
      end
      SEL_TOP: begin
        if (middle_base + middle_depth == CAPACITY - top_depth) shift_middle_down();
        top_depth++;
        slot = CAPACITY - top_depth;
      end
      default: begin
        if (middle_base + middle_depth == CAPACITY - top_depth) shift_middle_down();
        slot = middle_base + middle_depth;
        middle_depth++;
      end
    endcase
    if (slot < CAPACITY) shadow_words[slot] = value;
    return ST_OK;
  endfunction

  // Applies one request to the shadow stacks and returns the response it must produce.
  function automatic stack_result_t apply_request(logic [OPCODE_W-1:0] op,
                                                  logic [SEL_W-1:0] sel,
                                                  logic signed [WORD_W-1:0] value);
    stack_result_t res;
    int slot;
    res = '0;
    if (op == OP_PUSH) begin
      res.status = push_word(sel, value);
    end else if (op == OP_POP || op == OP_PEEK || op == OP_DROP) begin
      if (depth_of(sel) == 0) begin
        res.status = ST_EMPTY;
      end else begin
        case (sel)
          SEL_BOTTOM: slot = bottom_depth - 1;
          SEL_TOP:    slot = CAPACITY - top_depth;
          default:    slot = middle_base + middle_depth - 1;
        endcase
        if (op != OP_DROP && slot < CAPACITY) res.read_value = shadow_words[slot];
        if (op != OP_PEEK) begin
          case (sel)
            SEL_BOTTOM: bottom_depth--;
            SEL_TOP:    top_depth--;
            default:    middle_depth--;
          endcase
        end
      end
    end else if (op == OP_CLEAR) begin
      bottom_depth = 0;
      top_depth = 0;
      middle_depth = 0;
      middle_base = MID_RESET;
    end
    res.stack_empty = (depth_of(sel) == 0);
    return res;
  endfunction

  // Offers one request and returns at the clock edge that accepts it.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [SEL_W-1:0] sel,
                           input logic signed [WORD_W-1:0] value);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid = 1'b1;
    req_bus.opcode = op;
    req_bus.stack_select = sel;
    req_bus.push_value = value;
    do @(posedge clk_i); while (!req_bus.ready);
    pending_results.push_back(apply_request(op, sel, value));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_item(OP_POP, SEL_BOTTOM, 32'sd0);
    send_item(OP_PEEK, SEL_TOP, 32'sd0);
    send_item(OP_DROP, SEL_MIDDLE, 32'sd0);
    send_item(OP_QUERY, SEL_BOTTOM, 32'sd0);
    send_item(OP_PUSH, SEL_BOTTOM, 32'sh7fff_ffff);
    send_item(OP_PUSH, SEL_BOTTOM, 32'sh8000_0000);
    send_item(OP_PUSH, SEL_TOP, 32'sd0);
    send_item(OP_PUSH, SEL_TOP, -32'sd1);
    send_item(OP_PUSH, SEL_MIDDLE, 32'sh5555_5555);
    send_item(OP_PUSH, SEL_MIDDLE, 32'shaaaa_aaaa);
    send_item(OP_PEEK, SEL_BOTTOM, 32'sd0);
    send_item(OP_POP, SEL_BOTTOM, 32'sd0);
    send_item(OP_DROP, SEL_BOTTOM, 32'sd0);
    send_item(OP_QUERY, SEL_BOTTOM, 32'sd0);
    send_item(OP_PUSH, SEL_NONE, 32'sh1234_5678);
    send_item(OP_POP, SEL_NONE, 32'sd0);
    send_item(OP_PEEK, SEL_NONE, 32'sd0);
    send_item(OP_DROP, SEL_NONE, 32'sd0);
    send_item(OP_QUERY, SEL_NONE, 32'sd0);
    send_item(OP_NOP6, SEL_MIDDLE, -32'sd1);
    send_item(OP_NOP7, SEL_TOP, 32'sd0);
    send_item(OP_PEEK, SEL_MIDDLE, 32'sd0);
    send_item(OP_POP, SEL_TOP, 32'sd0);
    send_item(OP_CLEAR, SEL_MIDDLE, 32'sd0);
    send_item(OP_QUERY, SEL_TOP, 32'sd0);
    wait_drained();
  endtask

  // The top stack runs into the middle stack, then the bottom stack does, until the buffer
  // is full; pops afterwards read back the words that the shifts moved.
  task automatic test_stack_collisions();
    send_idle_pct = 50;
    recv_stall_pct = 0;
    send_item(OP_CLEAR, SEL_BOTTOM, 32'sd0);
    repeat (3) send_item(OP_PUSH, SEL_MIDDLE, $urandom());
    while (middle_base + middle_depth < CAPACITY - top_depth)
      send_item(OP_PUSH, SEL_TOP, $urandom());
    repeat (2) send_item(OP_PUSH, SEL_TOP, $urandom());
    send_item(OP_PUSH, SEL_MIDDLE, $urandom());
    while (bottom_depth + top_depth + middle_depth < CAPACITY)
      send_item(OP_PUSH, SEL_BOTTOM, $urandom());
    send_item(OP_PUSH, SEL_BOTTOM, $urandom());
    send_item(OP_PUSH, SEL_TOP, $urandom());
    send_item(OP_PUSH, SEL_MIDDLE, $urandom());
    send_item(OP_PEEK, SEL_MIDDLE, 32'sd0);
    repeat (55) send_item(OP_POP, SEL_W'($urandom_range(2)), 32'sd0);
    wait_drained();
  endtask

  // The response side holds off while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stall_hold = 60;
    repeat (10) begin
      send_item(OP_PUSH, SEL_W'($urandom_range(2)), $urandom());
      send_item(OP_POP, SEL_W'($urandom_range(2)), 32'sd0);
    end
    wait_drained();
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    logic [OPCODE_W-1:0] op;
    logic [SEL_W-1:0] sel;
    int pick;
    bit grow;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      // Alternate stretches that mostly fill and mostly empty the stacks.
      grow = ((n / 40) % 2) == 0;
      pick = $urandom_range(99);
      if (pick < 2) op = OP_CLEAR;
      else if (pick < 4) op = ($urandom_range(1) != 0) ? OP_NOP7 : OP_NOP6;
      else if (pick < 8) op = OP_QUERY;
      else if (pick < (grow ? 68 : 30)) op = OP_PUSH;
      else case ($urandom_range(2))
        0: op = OP_POP;
        1: op = OP_PEEK;
        default: op = OP_DROP;
      endcase
      sel = ($urandom_range(99) < 5) ? SEL_NONE : SEL_W'($urandom_range(2));
      send_item(op, sel, $urandom());
    end
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.opcode = OP_PUSH;
    req_bus.stack_select = SEL_BOTTOM;
    req_bus.push_value = '0;
    foreach (shadow_words[i]) shadow_words[i] = '0;
    bottom_depth = 0;
    top_depth = 0;
    middle_depth = 0;
    middle_base = MID_RESET;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_stack_collisions();
    test_backpressure();
    test_random(70, 0, 0);
    test_random(70, 50, 0);
    test_random(70, 0, 50);
    test_random(70, 33, 33);

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_hold > 0) begin
        rsp_bus.ready = 1'b0;
        stall_hold--;
      end else begin
        rsp_bus.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_responses
    stack_result_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $error("response with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.read_value !== want.read_value) begin
          mismatch_count++;
          $error("read_value: expected %0d, got %0d", want.read_value, rsp_bus.read_value);
        end
        if (rsp_bus.status !== want.status) begin
          mismatch_count++;
          $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
        end
        if (rsp_bus.stack_empty !== want.stack_empty) begin
          mismatch_count++;
          $error("stack_empty: expected %0d, got %0d", want.stack_empty,
                 rsp_bus.stack_empty);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/tsb_pkg.sv
hw/rtl/tsb_if.sv
hw/rtl/tsb_cell.sv
hw/rtl/tsb_ctrl.sv
hw/rtl/three_stacks_shared_buffer.sv
hw/rtl/tsb_checker.sv
bench/tb.sv
